/* src/frame_animation_sequencer_top_macros.svh */
// Assertion macros for the checker of the frame animation sequencer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FRAME_ANIMATION_SEQUENCER_TOP_MACROS_SVH
`define FRAME_ANIMATION_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame animation sequencer: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame animation sequencer: next-cycle check failed");

`endif

/* src/fas_pkg.sv */
// Package of the frame animation sequencer: widths, codes and the result type.
// Used by the top level and the checker; depends on nothing.
package fas_pkg;

  localparam int MaxFramesDefault = 16;
  localparam int TimeBitsDefault  = 32;

  localparam int ActionW     = 3;
  localparam int PortTimeW   = 32;
  localparam int DelayIdxW   = 4;
  localparam int FrameNumW   = 4;
  localparam int LoopModeW   = 2;
  localparam int FrameCountW = 5;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 8;

  typedef enum logic [ActionW-1:0] {
    ActTick  = 3'd0,
    ActPlay  = 3'd1,
    ActPause = 3'd2,
    ActHalt  = 3'd3,
    ActLoad  = 3'd4
  } action_e;

  localparam logic [LoopModeW-1:0] ModeOneOff = 2'd0;
  localparam logic [LoopModeW-1:0] ModeLoop   = 2'd1;
  localparam logic [LoopModeW-1:0] ModePing   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgLoopMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameCount = 2'd1;

  typedef struct packed {
    logic [FrameNumW-1:0] frame_number;
    logic                 showing_frame;
    logic                 frame_changed;
    logic                 end_event;
    logic                 done_res;
    logic                 held;
  } result_t;

endpackage

/* src/frame_animation_sequencer_top.sv */
// Top level of the frame animation sequencer: control state, tick logic, output skid.
// Depends on fas_pkg and fas_ram.
//
// Usage: items enter on the in_ channel (valid/stall) and carry an action, a time,
// and for load delay a frame index and a delay. Every accepted item yields exactly
// one result on the out_ channel, registered in the result or the skid register;
// one item can be accepted in every cycle while in_stall_o is low.
// The per-item work is one time subtraction and compare against the current frame's
// delay plus a small position update, all ahead of the result register. The delay
// of the next frame is read ahead from the delay RAM at the next position, with a
// bypass for a delay written to that frame in the same cycle.
// The cfg_ channel (valid/ready, always ready) writes loop_mode (index 0) and
// frame_count (index 1); the user uses it only while no item is in flight, which the block itself does not enforce.
// When the receiver stalls, the result register holds and one more item is taken
// into a skid register; in_stall_o rises only while that skid register is full.
// Reset clears the control state: the animation is finished and idle until play,
// at frame 0, not showing. Delays are undefined until loaded.
module frame_animation_sequencer_top #(
  parameter int MAX_FRAMES = fas_pkg::MaxFramesDefault,
  parameter int TIME_BITS  = fas_pkg::TimeBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fas_pkg::ActionW-1:0]      in_action_i,
  input  logic [fas_pkg::PortTimeW-1:0]    in_now_i,
  input  logic [fas_pkg::DelayIdxW-1:0]    in_delay_index_i,
  input  logic [fas_pkg::PortTimeW-1:0]    in_delay_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fas_pkg::FrameNumW-1:0]    out_frame_number_o,
  output logic                             out_showing_frame_o,
  output logic                             out_frame_changed_o,
  output logic                             out_end_event_o,
  output logic                             out_done_res_o,
  output logic                             out_held_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fas_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fas_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int PosW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW      = ($clog2(MAX_FRAMES + 1) > fas_pkg::FrameCountW) ?
                             $clog2(MAX_FRAMES + 1) : fas_pkg::FrameCountW;
  localparam int FrameNumW = fas_pkg::FrameNumW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAMES);

  logic [fas_pkg::LoopModeW-1:0]   loop_mode_q;
  logic [fas_pkg::FrameCountW-1:0] frame_count_q;

  logic [PosW-1:0]      pos_q, pos_d;
  logic                 back_q, back_d;
  logic                 fin_q, fin_d;
  logic                 paused_q, paused_d;
  logic                 show_q, show_d;
  logic [TIME_BITS-1:0] last_q, last_d;

  logic                 byp_hit_q;
  logic [TIME_BITS-1:0] byp_data_q;
  logic [TIME_BITS-1:0] ram_rdata;
  logic [TIME_BITS-1:0] delay_cur;

  fas_pkg::result_t main_q, skid_q, res_new;
  logic             main_valid_q, skid_valid_q;

  logic                 in_acc, out_pop;
  fas_pkg::action_e     action;
  logic [TIME_BITS-1:0] now_t, val_t, elapsed;
  logic [CntW-1:0]      fc_ext, fc_eff;
  logic                 ping, active, tick_fire, at_end, back_t;
  logic                 changed, ended, load_we;
  logic [PosW-1:0]      load_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q   <= fas_pkg::ModeOneOff;
      frame_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fas_pkg::CfgLoopMode:   loop_mode_q   <= cfg_data_i[fas_pkg::LoopModeW-1:0];
        fas_pkg::CfgFrameCount: frame_count_q <= cfg_data_i[fas_pkg::FrameCountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_pop    = main_valid_q && !out_stall_i;

  assign action    = fas_pkg::action_e'(in_action_i);
  assign now_t     = TIME_BITS'(in_now_i);
  assign val_t     = TIME_BITS'(in_delay_value_i);
  assign load_addr = PosW'(in_delay_index_i);

  assign delay_cur = byp_hit_q ? byp_data_q : ram_rdata;
  assign elapsed   = now_t - last_q;
  assign fc_ext    = CntW'(frame_count_q);
  assign fc_eff    = (fc_ext > MaxCnt) ? MaxCnt : fc_ext;
  assign ping      = (loop_mode_q == fas_pkg::ModePing);
  assign active    = !paused_q && !fin_q && (fc_eff != '0);
  assign tick_fire = active && (elapsed > delay_cur);
  assign at_end    = (CntW'(pos_q) + CntW'(1)) >= fc_eff;

  always_comb begin
    pos_d    = pos_q;
    back_d   = back_q;
    fin_d    = fin_q;
    paused_d = paused_q;
    show_d   = show_q;
    last_d   = last_q;
    changed  = 1'b0;
    ended    = 1'b0;
    load_we  = 1'b0;
    back_t   = ping && back_q;
    if (in_acc) begin
      unique case (action)
        fas_pkg::ActTick: begin
          if (tick_fire) begin
            last_d = now_t;
            if (at_end && (loop_mode_q == fas_pkg::ModeLoop)) begin
              pos_d   = '0;
              back_d  = 1'b0;
              show_d  = 1'b1;
              changed = 1'b1;
            end else begin
              if (at_end) begin
                if (ping) begin
                  back_t = !back_t;
                end else begin
                  fin_d = 1'b1;
                end
              end
              if (back_t && (pos_q == '0)) begin
                fin_d = 1'b1;
              end
              back_d = back_t;
              if (fin_d) begin
                show_d = 1'b0;
                ended  = 1'b1;
              end else begin
                pos_d   = back_t ? (pos_q - PosW'(1)) : (pos_q + PosW'(1));
                show_d  = 1'b1;
                changed = 1'b1;
              end
            end
          end
        end
        fas_pkg::ActPlay: begin
          fin_d    = 1'b0;
          paused_d = 1'b0;
          pos_d    = '0;
          back_d   = 1'b0;
          last_d   = now_t;
        end
        fas_pkg::ActPause: paused_d = 1'b1;
        fas_pkg::ActHalt:  fin_d    = 1'b1;
        fas_pkg::ActLoad:  load_we  = (CntW'(in_delay_index_i) < MaxCnt);
        default: ;
      endcase
    end
  end

  always_comb begin
    res_new.frame_number  = FrameNumW'(pos_d);
    res_new.showing_frame = show_d;
    res_new.frame_changed = changed;
    res_new.end_event     = ended;
    res_new.done_res      = fin_d;
    res_new.held          = paused_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      back_q    <= 1'b0;
      fin_q     <= 1'b1;
      paused_q  <= 1'b0;
      show_q    <= 1'b0;
      last_q    <= '0;
      byp_hit_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      back_q    <= back_d;
      fin_q     <= fin_d;
      paused_q  <= paused_d;
      show_q    <= show_d;
      last_q    <= last_d;
      byp_hit_q <= load_we && (load_addr == pos_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= val_t;
  end

  fas_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_FRAMES),
    .ADDR_W(PosW)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(load_addr),
    .wdata_i(val_t),
    .raddr_i(pos_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : res_new;
    end else if (in_acc) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o         = main_valid_q;
  assign out_frame_number_o  = main_q.frame_number;
  assign out_showing_frame_o = main_q.showing_frame;
  assign out_frame_changed_o = main_q.frame_changed;
  assign out_end_event_o     = main_q.end_event;
  assign out_done_res_o      = main_q.done_res;
  assign out_held_o          = main_q.held;

endmodule

/* src/fas_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the frame delay store; depends on nothing.
module fas_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/fas_checker.sv */
// Port-level checker for the frame animation sequencer, bound to the top level.
// Depends on fas_pkg and frame_animation_sequencer_top_macros.svh.
`include "frame_animation_sequencer_top_macros.svh"

module fas_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [fas_pkg::FrameNumW-1:0] out_frame_number_o,
  input logic                          out_showing_frame_o,
  input logic                          out_frame_changed_o,
  input logic                          out_end_event_o,
  input logic                          out_done_res_o,
  input logic                          out_held_o
);

  // A natural end leaves the animation finished with the original image restored.
  `FAS_ASSERT_NOW(a_end_finishes, out_valid_o && out_end_event_o,
                  out_done_res_o && !out_showing_frame_o && !out_frame_changed_o)

  // A frame change only happens on a running animation and shows that frame.
  `FAS_ASSERT_NOW(a_change_shows, out_valid_o && out_frame_changed_o,
                  out_showing_frame_o && !out_done_res_o)

  // A paused animation never moves or ends.
  `FAS_ASSERT_NOW(a_held_quiet, out_valid_o && out_held_o,
                  !out_frame_changed_o && !out_end_event_o)

  // A stalled result stays put.
  `FAS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_frame_number_o) && $stable(out_done_res_o)
                   && $stable(out_frame_changed_o) && $stable(out_end_event_o))

endmodule

bind frame_animation_sequencer_top fas_checker u_fas_checker (.*);

/* verif/frame_animation_sequencer_top_test.sv */
// Self-checking testbench for frame_animation_sequencer_top: a directed table, then random
// sequences of all actions under random idling, each checked against the table or a behavioral model.
// Depends on fas_pkg and the RTL of the block.
`timescale 1ns / 100ps

module frame_animation_sequencer_top_test;

  localparam int RandomItems = 1580;
  localparam int CycleLimit = 400000;
  localparam int LongHold = 80;
  localparam int ActW = fas_pkg::ActionW;
  localparam int ModeW = fas_pkg::LoopModeW;
  localparam int CfgW = fas_pkg::CfgDataW;
  localparam int FramesMax = fas_pkg::MaxFramesDefault;
  localparam logic [4:0] FramesCap = 5'(fas_pkg::MaxFramesDefault);
  localparam logic [ActW-1:0] ActUnusedFirst = 3'd5;
  localparam logic [ActW-1:0] ActUnusedLast = 3'd7;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  localparam fas_pkg::result_t StatusAtReset = '{frame_number: 4'd0, showing_frame: 1'b0,
    frame_changed: 1'b0, end_event: 1'b0, done_res: 1'b1, held: 1'b0};
  localparam fas_pkg::result_t StatusStarted = '{frame_number: 4'd0, showing_frame: 1'b0,
    frame_changed: 1'b0, end_event: 1'b0, done_res: 1'b0, held: 1'b0};

  typedef struct {
    logic                set_cfg;
    logic [ModeW-1:0]    mode;
    logic [4:0]          count;
    logic [ActW-1:0]     act;
    logic [31:0]         now;
    logic [3:0]          idx;
    logic [31:0]         val;
    logic                typed;
    fas_pkg::result_t    expected;
  } script_row_t;

  logic                                clk_i;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [fas_pkg::ActionW-1:0]         in_action_i = '0;
  logic [fas_pkg::PortTimeW-1:0]       in_now_i = '0;
  logic [fas_pkg::DelayIdxW-1:0]       in_delay_index_i = '0;
  logic [fas_pkg::PortTimeW-1:0]       in_delay_value_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [fas_pkg::FrameNumW-1:0]       out_frame_number_o;
  logic                                out_showing_frame_o;
  logic                                out_frame_changed_o;
  logic                                out_end_event_o;
  logic                                out_done_res_o;
  logic                                out_held_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [fas_pkg::CfgIdxW-1:0]         cfg_index_i = '0;
  logic [fas_pkg::CfgDataW-1:0]        cfg_data_i = '0;

  // Behavioral copy of the sequencer state.
  logic [ModeW-1:0]     mode_q = fas_pkg::ModeOneOff;
  logic [4:0]           count_q = '0;
  logic [3:0]           pos_q = '0;
  logic                 backward_q = 1'b0;
  logic                 finished_q = 1'b1;
  logic                 paused_q = 1'b0;
  logic                 showing_q = 1'b0;
  logic [31:0]          last_change_q = '0;
  logic [31:0]          delay_mem [FramesMax];
  logic                 delay_loaded [FramesMax];

  fas_pkg::result_t pending_status [$];
  script_row_t      script [$];
  int               failures = 0;
  int               cycle_count = 0;
  int               send_pct = 33;
  int               recv_pct = 63;
  logic             hold_request = 1'b0;
  int               hold_count = 0;
  logic [31:0]      time_cursor = '0;

  frame_animation_sequencer_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_action_i,
    .in_now_i,
    .in_delay_index_i,
    .in_delay_value_i,
    .out_valid_o,
    .out_stall_i,
    .out_frame_number_o,
    .out_showing_frame_o,
    .out_frame_changed_o,
    .out_end_event_o,
    .out_done_res_o,
    .out_held_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] frames_in_use();
    return (count_q > FramesCap) ? FramesCap : count_q;
  endfunction

  function automatic fas_pkg::result_t advance_animation(input logic [ActW-1:0] act,
                                                         input logic [31:0] now,
                                                         input logic [3:0] idx,
                                                         input logic [31:0] val);
    fas_pkg::result_t status;
    logic [4:0]       fc;
    logic [31:0]      elapsed;
    logic             ping;
    logic             back;
    logic             wrapped;
    logic             changed;
    logic             ended;
    changed = 1'b0;
    ended = 1'b0;
    case (act)
      fas_pkg::ActTick: begin
        fc = frames_in_use();
        ping = (mode_q == fas_pkg::ModePing);
        elapsed = now - last_change_q;
        if (!paused_q && !finished_q && fc != 0 && elapsed > delay_mem[pos_q]) begin
          last_change_q = now;
          wrapped = 1'b0;
          if (!ping) backward_q = 1'b0;
          if ({1'b0, pos_q} >= fc - 5'd1) begin
            if (mode_q == fas_pkg::ModeLoop) begin
              pos_q = '0;
              changed = 1'b1;
              showing_q = 1'b1;
              wrapped = 1'b1;
            end else if (ping) begin
              backward_q = !backward_q;
            end else begin
              finished_q = 1'b1;
            end
          end
          if (!wrapped) begin
            back = ping && backward_q;
            if (back && pos_q == 0) finished_q = 1'b1;
            if (finished_q) begin
              showing_q = 1'b0;
              ended = 1'b1;
            end else begin
              pos_q = back ? pos_q - 4'd1 : pos_q + 4'd1;
              showing_q = 1'b1;
              changed = 1'b1;
            end
          end
        end
      end
      fas_pkg::ActPlay: begin
        finished_q = 1'b0;
        paused_q = 1'b0;
        pos_q = '0;
        backward_q = 1'b0;
        last_change_q = now;
      end
      fas_pkg::ActPause: paused_q = 1'b1;
      fas_pkg::ActHalt: finished_q = 1'b1;
      fas_pkg::ActLoad: begin
        delay_mem[idx] = val;
        delay_loaded[idx] = 1'b1;
      end
      default: ;
    endcase
    status.frame_number = pos_q;
    status.showing_frame = showing_q;
    status.frame_changed = changed;
    status.end_event = ended;
    status.done_res = finished_q;
    status.held = paused_q;
    return status;
  endfunction

  task automatic enqueue_status(input fas_pkg::result_t status);
    pending_status.insert(pending_status.size(), status);
  endtask

  task automatic offer_item(input logic [ActW-1:0] act, input logic [31:0] now,
                            input logic [3:0] idx, input logic [31:0] val,
                            output fas_pkg::result_t predicted);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_action_i <= act;
    in_now_i <= now;
    in_delay_index_i <= idx;
    in_delay_value_i <= val;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predicted = advance_animation(act, now, idx, val);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [fas_pkg::CfgIdxW-1:0] index,
                                input logic [fas_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (index == fas_pkg::CfgLoopMode) mode_q = data[ModeW-1:0];
    else if (index == fas_pkg::CfgFrameCount) count_q = data[4:0];
  endtask

  task automatic reconfigure(input logic [ModeW-1:0] mode, input logic [4:0] count);
    wait_idle();
    write_register(fas_pkg::CfgLoopMode, CfgW'(mode));
    write_register(fas_pkg::CfgFrameCount, CfgW'(count));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input logic set_cfg, input logic [ModeW-1:0] mode,
                         input logic [4:0] count, input logic [ActW-1:0] act,
                         input logic [31:0] now, input logic [3:0] idx,
                         input logic [31:0] val, input logic typed,
                         input fas_pkg::result_t expected);
    script_row_t row;
    row.set_cfg = set_cfg;
    row.mode = mode;
    row.count = count;
    row.act = act;
    row.now = now;
    row.idx = idx;
    row.val = val;
    row.typed = typed;
    row.expected = expected;
    script.insert(script.size(), row);
  endtask

  task automatic send_random_item();
    int               pick;
    logic [ActW-1:0]  act;
    logic [31:0]      now;
    logic [3:0]       idx;
    logic [31:0]      val;
    fas_pkg::result_t predicted;
    pick = $urandom_range(0, 99);
    now = $urandom;
    idx = 4'($urandom);
    val = $urandom;
    if ((finished_q || paused_q) && $urandom_range(0, 1) == 1) pick = 70;
    if (pick < 60) begin
      act = fas_pkg::ActTick;
      if ($urandom_range(0, 19) != 0) begin
        time_cursor = time_cursor + $urandom_range(0, 14);
        now = time_cursor;
      end
    end else if (pick < 70) begin
      act = fas_pkg::ActLoad;
      case ($urandom_range(0, 15))
        0: val = '1;
        1: val = $urandom;
        default: val = $urandom_range(0, 12);
      endcase
    end else if (pick < 80) begin
      act = fas_pkg::ActPlay;
      time_cursor = now;
    end else if (pick < 85) begin
      act = fas_pkg::ActPause;
    end else if (pick < 89) begin
      act = fas_pkg::ActHalt;
    end else if (pick < 94) begin
      act = ActW'($urandom_range(ActUnusedFirst, ActUnusedLast));
    end else begin
      act = ActW'($urandom_range(fas_pkg::ActTick, ActUnusedLast));
    end
    // A running tick must never read a delay that has not been loaded yet.
    if (act == fas_pkg::ActTick && !paused_q && !finished_q && frames_in_use() != 0 &&
        !delay_loaded[pos_q]) begin
      act = fas_pkg::ActLoad;
      idx = pos_q;
      val = $urandom_range(0, 12);
    end
    offer_item(act, now, idx, val, predicted);
    enqueue_status(predicted);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    fas_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual frame %0d", $time,
                 out_frame_number_o);
        failures++;
      end else begin
        want = pending_status.pop_front();
        check_field("frame_number", want.frame_number, out_frame_number_o);
        check_field("showing_frame", want.showing_frame, out_showing_frame_o);
        check_field("frame_changed", want.frame_changed, out_frame_changed_o);
        check_field("end_event", want.end_event, out_end_event_o);
        check_field("done_res", want.done_res, out_done_res_o);
        check_field("held", want.held, out_held_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request && hold_count < LongHold) begin
      out_stall_i <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    fas_pkg::result_t predicted;
    int               sent;
    int               seg;
    logic [ModeW-1:0] mode;
    logic [4:0]       count;
    for (int i = 0; i < FramesMax; i++) begin
      delay_mem[i] = '0;
      delay_loaded[i] = 1'b0;
    end

    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd0, 4'd0, 32'd0, 1'b1,
            StatusAtReset);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, ActUnusedFirst, 32'd0, 4'd0, 32'd0, 1'b1,
            StatusAtReset);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, ActUnusedLast, '1, '1, '1, 1'b1,
            StatusAtReset);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActLoad, 32'd0, 4'd0, 32'd0, 1'b1,
            StatusAtReset);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActLoad, 32'd0, 4'd1, 32'd3, 1'b1,
            StatusAtReset);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActLoad, 32'd0, 4'd2, 32'd1, 1'b1,
            StatusAtReset);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActLoad, 32'd0, 4'd3, 32'hFFFF_FFFF,
            1'b1, StatusAtReset);
    add_row(1'b1, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActPlay, 32'd0, 4'd0, 32'd0, 1'b1,
            StatusStarted);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd50, 4'd0, 32'd0, 1'b1,
            StatusStarted);
    add_row(1'b1, fas_pkg::ModeOneOff, 5'd3, fas_pkg::ActPlay, 32'hFFFF_FFFE, 4'd0, 32'd0,
            1'b1, StatusStarted);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd0, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd3, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd4, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd6, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModeOneOff, 5'd0, fas_pkg::ActTick, 32'd100, 4'd0, 32'd0, 1'b0,
            '0);
    add_row(1'b1, fas_pkg::ModePing, 5'd3, fas_pkg::ActPlay, 32'd0, 4'd0, 32'd0, 1'b1,
            StatusStarted);
    add_row(1'b0, fas_pkg::ModePing, 5'd0, fas_pkg::ActTick, 32'd1, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModePing, 5'd0, fas_pkg::ActTick, 32'd5, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModePing, 5'd0, fas_pkg::ActTick, 32'd7, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModePing, 5'd0, fas_pkg::ActTick, 32'd11, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModePing, 5'd0, fas_pkg::ActTick, 32'd12, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b1, fas_pkg::ModeLoop, 5'd1, fas_pkg::ActPlay, 32'd0, 4'd0, 32'd0, 1'b1,
            StatusStarted);
    add_row(1'b0, fas_pkg::ModeLoop, 5'd0, fas_pkg::ActTick, 32'd1, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModeLoop, 5'd0, fas_pkg::ActPause, 32'd0, 4'd0, 32'd0, 1'b0, '0);
    add_row(1'b0, fas_pkg::ModeLoop, 5'd0, fas_pkg::ActTick, 32'd1000, 4'd0, 32'd0, 1'b0,
            '0);
    add_row(1'b0, fas_pkg::ModeLoop, 5'd0, fas_pkg::ActHalt, 32'd0, 4'd0, 32'd0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].set_cfg) reconfigure(script[i].mode, script[i].count);
      offer_item(script[i].act, script[i].now, script[i].idx, script[i].val, predicted);
      enqueue_status(script[i].typed ? script[i].expected : predicted);
    end

    sent = 0;
    seg = 0;
    while (sent < RandomItems) begin
      if (sent < RandomItems / 3) begin
        send_pct = 33;
        recv_pct <= 63;
      end else if (sent < 2 * RandomItems / 3) begin
        send_pct = 63;
        recv_pct <= 33;
      end else begin
        send_pct = 0;
        recv_pct <= 0;
      end
      mode = ModeW'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: count = 5'd0;
        1: count = 5'($urandom_range(17, 31));
        2: count = FramesCap;
        default: count = 5'($urandom_range(1, 5));
      endcase
      case (seg)
        0: begin mode = ModeUnused; count = 5'd31; end
        1: begin mode = fas_pkg::ModeOneOff; count = 5'd0; end
        2: begin mode = fas_pkg::ModePing; count = FramesCap; end
        3: begin mode = fas_pkg::ModeLoop; count = FramesCap; end
        default: ;
      endcase
      reconfigure(mode, count);
      if (send_pct == 0) hold_request <= 1'b1;
      repeat ($urandom_range(20, 60)) begin
        send_random_item();
        sent++;
      end
      seg++;
    end

    wait_idle();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/fas_pkg.sv
src/fas_ram.sv
src/frame_animation_sequencer_top.sv
src/fas_checker.sv
verif/frame_animation_sequencer_top_test.sv
